@@ hdl/ufd_pkg.sv @@
// ----------------------------------------------------------------------------
// ufd_pkg: shared types and constants for the baud divisor and frame encoder
// Beat structs, field widths, line control and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ufd_pkg;

  localparam int BAUD_W  = 22;
  localparam int CLK_W   = 27;
  localparam int BYTE_W  = 8;
  localparam int IDIV_W  = 16;
  localparam int FRAC_W  = 6;
  localparam int STAT_W  = 2;
  localparam int OVS_LOG = 3;
  localparam int NUM_W   = CLK_W + OVS_LOG;
  localparam int QLO_W   = FRAC_W + 1;
  localparam int IRAW_W  = NUM_W - QLO_W;

  localparam logic [CLK_W-1:0] CLK_RESET_HZ = CLK_W'(14745600);

  localparam logic [BYTE_W-1:0] LCR_FIFO_EN = 8'h10;
  localparam logic [BYTE_W-1:0] BITS_MIN    = 8'd5;
  localparam logic [BYTE_W-1:0] BITS_MAX    = 8'd8;
  localparam logic [BYTE_W-1:0] PAR_NONE    = 8'd0;
  localparam logic [BYTE_W-1:0] PAR_EVEN    = 8'd1;
  localparam logic [BYTE_W-1:0] PAR_ODD     = 8'd255;
  localparam logic [BYTE_W-1:0] STOP_ONE    = 8'd1;
  localparam logic [BYTE_W-1:0] STOP_TWO    = 8'd2;
  localparam logic [1:0]        PSEL_EVEN   = 2'b11;
  localparam logic [1:0]        PSEL_ODD    = 2'b01;
  localparam logic [1:0]        PSEL_NONE   = 2'b00;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FRAME = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [BAUD_W-1:0] rate_bps;
    logic [BYTE_W-1:0] data_bit_count;
    logic [BYTE_W-1:0] parity_code;
    logic [BYTE_W-1:0] stop_bit_count;
  } ufd_in_t;

  typedef struct packed {
    logic [IDIV_W-1:0] integer_divisor;
    logic [FRAC_W-1:0] fraction_divisor;
    logic [BYTE_W-1:0] line_control;
    logic [STAT_W-1:0] status;
  } ufd_out_t;

  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [BAUD_W-1:0] rem;
    logic [NUM_W-1:0]  quo;
    logic [BAUD_W-1:0] baud;
    logic [BYTE_W-1:0] lcr;
    logic              frame_ok;
  } ufd_cell_t;

  typedef struct packed {
    logic [BYTE_W-1:0] lcr;
    logic              frame_ok;
  } ufd_frame_t;

endpackage

`default_nettype wire

@@ hdl/ufd_frame_enc.sv @@
// ----------------------------------------------------------------------------
// ufd_frame_enc: line control byte encoder
// Packs word length, parity and stop bits and checks the frame setting.
// ----------------------------------------------------------------------------
`default_nettype none

module ufd_frame_enc (
  input  wire  ufd_pkg::ufd_in_t    in_data,
  output ufd_pkg::ufd_frame_t       frame
);

  logic [1:0] psel;
  logic       par_ok;
  logic       bits_ok;
  logic       stop_ok;
  logic [1:0] len;
  logic [ufd_pkg::BYTE_W-1:0] bits_off;

  always_comb begin
    psel   = ufd_pkg::PSEL_NONE;
    par_ok = 1'b1;
    unique case (in_data.parity_code)
      ufd_pkg::PAR_NONE: psel = ufd_pkg::PSEL_NONE;
      ufd_pkg::PAR_EVEN: psel = ufd_pkg::PSEL_EVEN;
      ufd_pkg::PAR_ODD:  psel = ufd_pkg::PSEL_ODD;
      default:           par_ok = 1'b0;
    endcase
  end

  assign bits_ok  = (in_data.data_bit_count >= ufd_pkg::BITS_MIN) &&
                    (in_data.data_bit_count <= ufd_pkg::BITS_MAX);
  assign bits_off = in_data.data_bit_count - ufd_pkg::BITS_MIN;
  assign len      = bits_off[1:0];
  assign stop_ok  = (in_data.stop_bit_count == ufd_pkg::STOP_ONE) ||
                    (in_data.stop_bit_count == ufd_pkg::STOP_TWO);

  assign frame.frame_ok = bits_ok && par_ok && stop_ok;
  assign frame.lcr      = frame.frame_ok ?
                          (ufd_pkg::LCR_FIFO_EN |
                           {1'b0, len, 1'b0,
                            (in_data.stop_bit_count == ufd_pkg::STOP_TWO),
                            psel, 1'b0}) :
                          '0;

endmodule

`default_nettype wire

@@ hdl/ufd_div_cell.sv @@
// ----------------------------------------------------------------------------
// ufd_div_cell: one restoring division cell
// Shifts in one numerator bit, subtracts the baud rate, emits a quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ufd_div_cell (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      adv,
  input  wire                      in_vld,
  input  wire  ufd_pkg::ufd_cell_t in_cell,
  output logic                     out_vld,
  output ufd_pkg::ufd_cell_t       out_cell
);

  logic [ufd_pkg::BAUD_W:0] trial;
  logic [ufd_pkg::BAUD_W:0] diff;
  logic                     ge;
  ufd_pkg::ufd_cell_t       cell_nxt;
  ufd_pkg::ufd_cell_t       cell_r;
  logic                     vld_r;

  assign trial = {in_cell.rem, in_cell.num[ufd_pkg::NUM_W-1]};
  assign ge    = trial >= {1'b0, in_cell.baud};
  assign diff  = trial - {1'b0, in_cell.baud};

  always_comb begin
    cell_nxt     = in_cell;
    cell_nxt.rem = ge ? diff[ufd_pkg::BAUD_W-1:0] : trial[ufd_pkg::BAUD_W-1:0];
    cell_nxt.num = {in_cell.num[ufd_pkg::NUM_W-2:0], 1'b0};
    cell_nxt.quo = {in_cell.quo[ufd_pkg::NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_cell = cell_r;

endmodule

`default_nettype wire

@@ hdl/ufd_finish.sv @@
// ----------------------------------------------------------------------------
// ufd_finish: divisor rounding, carry, range check and status
// Splits the quotient into integer and rounded fraction and sets status.
// ----------------------------------------------------------------------------
`default_nettype none

module ufd_finish (
  input  wire  ufd_pkg::ufd_cell_t tail,
  output ufd_pkg::ufd_out_t        res
);

  logic [ufd_pkg::IRAW_W-1:0] idiv_raw;
  logic [ufd_pkg::QLO_W-1:0]  qlo;
  logic [ufd_pkg::QLO_W-1:0]  frac_sum;
  logic [ufd_pkg::IRAW_W:0]   idiv_c;
  logic [ufd_pkg::FRAC_W-1:0] frac_c;
  logic                       baud_zero;
  logic                       range_bad;

  assign idiv_raw  = tail.quo[ufd_pkg::NUM_W-1:ufd_pkg::QLO_W];
  assign qlo       = tail.quo[ufd_pkg::QLO_W-1:0];
  assign frac_sum  = {1'b0, qlo[ufd_pkg::QLO_W-1:1]} +
                     {{(ufd_pkg::QLO_W-1){1'b0}}, qlo[0]};
  assign idiv_c    = {1'b0, idiv_raw} +
                     {{ufd_pkg::IRAW_W{1'b0}}, frac_sum[ufd_pkg::FRAC_W]};
  assign frac_c    = frac_sum[ufd_pkg::FRAC_W] ? '0 : frac_sum[ufd_pkg::FRAC_W-1:0];
  assign baud_zero = (tail.baud == '0);

  always_comb begin
    res.line_control = tail.lcr;
    range_bad        = 1'b0;
    if (baud_zero) begin
      range_bad            = 1'b1;
      res.integer_divisor  = '0;
      res.fraction_divisor = '0;
    end else if (idiv_c[ufd_pkg::IRAW_W:ufd_pkg::IDIV_W] != '0) begin
      range_bad            = 1'b1;
      res.integer_divisor  = '1;
      res.fraction_divisor = '1;
    end else begin
      range_bad            = (idiv_c == '0);
      res.integer_divisor  = idiv_c[ufd_pkg::IDIV_W-1:0];
      res.fraction_divisor = frac_c;
    end
    if (!tail.frame_ok) begin
      res.status = ufd_pkg::ST_FRAME;
    end else if (range_bad) begin
      res.status = ufd_pkg::ST_RANGE;
    end else begin
      res.status = ufd_pkg::ST_OK;
    end
  end

endmodule

`default_nettype wire

@@ hdl/uart_divisor_and_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// uart_divisor_and_frame_encoder: UART baud divisor and line control encoder
// Turns a requested line setting into integer/fractional divisor, LCR byte
// and status.
//
// Input channel in_valid/in_stall/in_data carries one line setting a beat.
// Output channel out_valid/out_stall/out_data returns one result a beat.
// cfg_we/cfg_wdata writes the reference clock in hertz; write it only while
// no beat is in flight.
// The divide 8*clock/baud runs as a row of 30 restoring cells, one quotient
// bit per cell, followed by the output register; one beat is taken every
// cycle while the receiver does not stall a held result.
// When the receiver stalls a held result, the whole row freezes and in_stall
// rises in the same cycle; otherwise input beats flow at one per cycle.
// Reset empties the row and the output register and sets the reference
// clock to 14745600 Hz.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_divisor_and_frame_encoder (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_we,
  input  wire  [ufd_pkg::CLK_W-1:0]  cfg_wdata,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire  ufd_pkg::ufd_in_t     in_data,
  output logic                       out_valid,
  input  wire                        out_stall,
  output ufd_pkg::ufd_out_t          out_data
);

  localparam int STAGES = ufd_pkg::NUM_W;

  logic [ufd_pkg::CLK_W-1:0] ref_clk_r;
  logic                      adv;
  ufd_pkg::ufd_frame_t       frame;
  ufd_pkg::ufd_cell_t        head;
  ufd_pkg::ufd_cell_t        chain_cell [STAGES+1];
  logic                      chain_vld  [STAGES+1];
  ufd_pkg::ufd_out_t         res;
  ufd_pkg::ufd_out_t         out_data_r;
  logic                      out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_clk_r <= ufd_pkg::CLK_RESET_HZ;
    end else if (cfg_we) begin
      ref_clk_r <= cfg_wdata;
    end
  end

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  ufd_frame_enc u_frame (
    .in_data (in_data),
    .frame   (frame)
  );

  always_comb begin
    head          = '0;
    head.num      = {ref_clk_r, {ufd_pkg::OVS_LOG{1'b0}}};
    head.baud     = in_data.rate_bps;
    head.lcr      = frame.lcr;
    head.frame_ok = frame.frame_ok;
  end

  assign chain_cell[0] = head;
  assign chain_vld[0]  = in_valid;

  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    ufd_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (chain_vld[g]),
      .in_cell  (chain_cell[g]),
      .out_vld  (chain_vld[g+1]),
      .out_cell (chain_cell[g+1])
    );
  end

  ufd_finish u_finish (
    .tail (chain_cell[STAGES]),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain_vld[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
